// File: rtl/core/assert_macros.svh
// Assertion macros shared by the extent range cache RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ERC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ERC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/erc_pkg.sv
// Package for the extent range cache: sizes, operation codes and the
// command and status structs between controller and datapath. No dependencies.
package erc_pkg;

  localparam int ENTRIES = 8;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int OP_W   = 2;
  localparam int KEY_W  = 32;
  localparam int PHYS_W = 48;
  localparam int LEN_W  = 15;

  localparam int IN_TDATA_W  = 96;  // key, physical start, length, padded to bytes
  localparam int OUT_TDATA_W = 64;  // physical block, run length, padded to bytes

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_INVAL  = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic load_req;  // capture the input word
    logic do_match;  // register the per-entry compares
    logic do_pick;   // priority pick, table update
    logic do_emit;   // load the output register
  } erc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;  // output register can take a word this cycle
  } erc_sts_t;

endpackage

// File: rtl/core/erc_ctrl.sv
// Controller state machine of the extent range cache.
// Depends on erc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module erc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  erc_pkg::erc_sts_t sts,
  output erc_pkg::erc_cmd_t cmds
);
  import erc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_MATCH   = 4'b0010,
    ST_PICK    = 4'b0100,
    ST_EMIT    = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmds          = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmds.load_req = 1'b1;
          state_nxt     = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmds.do_match = 1'b1;
        state_nxt     = ST_PICK;
      end
      ST_PICK: begin
        cmds.do_pick = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmds.do_emit = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ERC_ASSERT_NXT(a_load_to_match, cmds.load_req, state_r == ST_MATCH, "load did not start match")
  `ERC_ASSERT_NXT(a_emit_holds, (state_r == ST_EMIT) && !sts.out_free, state_r == ST_EMIT, "emit left while output busy")
  `ERC_ASSERT_IMP(a_ready_idle, in_tready, !cmds.do_pick && !cmds.do_emit, "ready outside idle")

endmodule

// File: rtl/core/erc_datapath.sv
// Datapath of the extent range cache: request register, entry table,
// range compares, priority pick, result arithmetic and output register.
// Depends on erc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module erc_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  erc_pkg::erc_cmd_t             cmds,
  output erc_pkg::erc_sts_t             sts,
  input  logic [erc_pkg::OP_W-1:0]      req_op,
  input  logic [erc_pkg::KEY_W-1:0]     req_key,
  input  logic [erc_pkg::PHYS_W-1:0]    req_pstart,
  input  logic [erc_pkg::LEN_W-1:0]     req_len,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic                          out_hit,
  output logic [erc_pkg::PHYS_W-1:0]    out_phys,
  output logic [erc_pkg::LEN_W-1:0]     out_run
);
  import erc_pkg::*;

  // Request register.
  logic [OP_W-1:0]   op_r;
  logic [KEY_W-1:0]  key_r;
  logic [PHYS_W-1:0] pstart_r;
  logic [LEN_W-1:0]  len_r;

  // Entry table.
  logic [ENTRIES-1:0] valid_r;
  logic [KEY_W-1:0]   ent_start_r [ENTRIES];
  logic [PHYS_W-1:0]  ent_phys_r  [ENTRIES];
  logic [LEN_W-1:0]   ent_len_r   [ENTRIES];
  logic [IDX_W-1:0]   ptr_r;

  // Compare results.
  logic [ENTRIES-1:0] contain_r;
  logic [ENTRIES-1:0] same_r;
  logic [ENTRIES-1:0] contain_nxt;
  logic [ENTRIES-1:0] same_nxt;

  // Picked entry.
  logic [IDX_W-1:0] hit_idx;
  logic             hit_any;
  logic [IDX_W-1:0] upd_idx;
  logic             upd_any;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] ptr_nxt;

  logic              hit_r;
  logic [PHYS_W-1:0] sel_phys_r;
  logic [LEN_W-1:0]  sel_len_r;
  logic [LEN_W-1:0]  off_r;

  // Output register.
  logic              out_valid_r;
  logic              out_hit_r;
  logic [PHYS_W-1:0] out_phys_r;
  logic [LEN_W-1:0]  out_run_r;

  always_ff @(posedge clk) begin
    if (cmds.load_req) begin
      op_r     <= req_op;
      key_r    <= req_key;
      pstart_r <= req_pstart;
      len_r    <= req_len;
    end
  end

  // Containment is checked on 33 bits so an extent never wraps.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      contain_nxt[i] = valid_r[i] && (key_r >= ent_start_r[i]) &&
                       ({1'b0, key_r} <
                        ({1'b0, ent_start_r[i]} + {{(KEY_W + 1 - LEN_W){1'b0}}, ent_len_r[i]}));
      same_nxt[i]    = valid_r[i] && (ent_start_r[i] == key_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmds.do_match) begin
      contain_r <= contain_nxt;
      same_r    <= same_nxt;
    end
  end

  // Lowest index wins.
  always_comb begin
    hit_idx = '0;
    hit_any = 1'b0;
    upd_idx = '0;
    upd_any = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (contain_r[i]) begin
        hit_idx = IDX_W'(i);
        hit_any = 1'b1;
      end
      if (same_r[i]) begin
        upd_idx = IDX_W'(i);
        upd_any = 1'b1;
      end
    end
    wr_idx  = upd_any ? upd_idx : ptr_r;
    ptr_nxt = (ptr_r == IDX_W'(ENTRIES - 1)) ? '0 : ptr_r + 1'b1;
  end

  // Offset is below the length, so its low bits are enough.
  always_ff @(posedge clk) begin
    if (cmds.do_pick) begin
      hit_r      <= hit_any && (op_r == OP_LOOKUP);
      sel_phys_r <= ent_phys_r[hit_idx];
      sel_len_r  <= ent_len_r[hit_idx];
      off_r      <= key_r[LEN_W-1:0] - ent_start_r[hit_idx][LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmds.do_pick && (op_r == OP_INSERT)) begin
      ent_start_r[wr_idx] <= key_r;
      ent_phys_r[wr_idx]  <= pstart_r;
      ent_len_r[wr_idx]   <= len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ptr_r   <= '0;
    end else if (cmds.do_pick) begin
      if (op_r == OP_INSERT) begin
        valid_r[wr_idx] <= 1'b1;
        if (!upd_any) begin
          ptr_r <= ptr_nxt;
        end
      end else if (op_r == OP_INVAL) begin
        valid_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmds.do_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmds.do_emit) begin
      out_hit_r  <= hit_r;
      out_phys_r <= hit_r ? (sel_phys_r + {{(PHYS_W - LEN_W){1'b0}}, off_r}) : '0;
      out_run_r  <= hit_r ? (sel_len_r - off_r) : '0;
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_phys     = out_phys_r;
  assign out_run      = out_run_r;

  `ERC_ASSERT_NXT(a_inval_clears, cmds.do_pick && (op_r == OP_INVAL), valid_r == '0, "invalidate left a valid entry")
  `ERC_ASSERT_IMP(a_hit_run, out_valid_r && out_hit_r, out_run_r != '0, "hit with empty run")
  `ERC_ASSERT_IMP(a_miss_zero, out_valid_r && !out_hit_r, (out_phys_r == '0) && (out_run_r == '0), "miss with data")

endmodule

// File: rtl/core/extent_range_cache.sv
// Top level of the extent range cache: stream ports, controller and datapath.
// Depends on erc_pkg, erc_ctrl and erc_datapath.
//
// The block holds ENTRIES extent mappings in a fully associative table. Each
// input word carries an operation in in_tuser: lookup, insert or update, or
// invalidate all; the unused operation code changes nothing. Every input word
// gives exactly one output word. A lookup returns, for the lowest-indexed
// valid entry whose range contains the key, the hit flag in out_tuser, the
// physical block (start plus offset, wrapping at 2^48) and the blocks left in
// the extent; a miss and every other operation return all zeros.
// An insert rewrites a valid entry with the same logical start, or else
// writes at a round-robin pointer that then advances.
// Timing: a word is taken in the idle state, the range compares are
// registered in the next cycle, the priority pick and the table update follow,
// and the output register is loaded in the emit state once it is free.
// The controller passes through its four states in order for each word, so a
// new word is taken only after the last one has left the emit state. The output
// register lets the next word be taken while a result still waits. If the
// receiver stalls, the controller holds in its last state until the output
// register frees. Reset clears every valid bit, the pointer, the controller
// and out_tvalid at once; entry contents are not cleared.

module extent_range_cache (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // Fields from bit 0: logical_block[31:0], phys_start[79:32], length[94:80].
  input  logic [erc_pkg::IN_TDATA_W-1:0]     in_tdata,
  // Fields from bit 0: cmd[1:0].
  input  logic [erc_pkg::OP_W-1:0]           in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // Fields from bit 0: phys_block[47:0], run_length[62:48].
  output logic [erc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Fields from bit 0: hit[0].
  output logic                               out_tuser
);
  import erc_pkg::*;

  erc_cmd_t          cmds;
  erc_sts_t          sts;
  logic              res_hit;
  logic [PHYS_W-1:0] res_phys;
  logic [LEN_W-1:0]  res_run;

  erc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmds      (cmds)
  );

  erc_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmds       (cmds),
    .sts        (sts),
    .req_op     (in_tuser),
    .req_key    (in_tdata[KEY_W-1:0]),
    .req_pstart (in_tdata[KEY_W+PHYS_W-1:KEY_W]),
    .req_len    (in_tdata[KEY_W+PHYS_W+LEN_W-1:KEY_W+PHYS_W]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_hit    (res_hit),
    .out_phys   (res_phys),
    .out_run    (res_run)
  );

  // The upper input padding bit is ignored; the output padding bit is zero.
  assign out_tdata = {{(OUT_TDATA_W - PHYS_W - LEN_W){1'b0}}, res_run, res_phys};
  assign out_tuser = res_hit;

endmodule

// File: bench/testbench.sv
// Self-checking bench for extent_range_cache: directed words from a table, then random
// traffic, scored against typed rows' results or a behavioural extent table held here.
// Depends on erc_pkg and the extent_range_cache RTL only.
`timescale 1ns / 1ps

module testbench;
  import erc_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;  // spare code, must change nothing
  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 4;
  localparam int WORDS_PHASE  = 250;
  localparam int DRAIN_CYCLES = 16;      // idle clocks after the final drain
  localparam int CYCLE_LIMIT  = 200000;  // far beyond the slowest legal run
  localparam int POOL_DEPTH   = 16;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic              hit;
    logic [PHYS_W-1:0] phys;
    logic [LEN_W-1:0]  run;
  } extent_result_t;

  // One row of the directed part. When typed is set the row carries its own
  // expected result; otherwise the model below supplies it.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key;
    logic [PHYS_W-1:0] pstart;
    logic [LEN_W-1:0]  len;
    logic              typed;
    extent_result_t    res;
  } directed_row_t;

  // Extents recently inserted, used to aim lookups inside and at the edges
  // of their ranges and to reuse their logical starts in inserts.
  typedef struct {
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
  } extent_span_t;

  localparam extent_result_t NO_HIT = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [OP_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;

  // Behavioural copy of the extent table.
  logic [ENTRIES-1:0] map_valid;
  logic [KEY_W-1:0]   map_lstart [ENTRIES];
  logic [PHYS_W-1:0]  map_pstart [ENTRIES];
  logic [LEN_W-1:0]   map_len [ENTRIES];
  int                 victim_ptr;

  extent_result_t pending_results [$];
  extent_span_t   span_pool [$];
  directed_row_t  directed_rows [0:22];

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int mismatches = 0;
  int words_sent = 0;
  int words_checked = 0;
  int n_lookups = 0;
  int n_hits = 0;
  int n_inserts = 0;
  int n_updates = 0;
  int n_wipes = 0;
  int cycle_count = 0;

  extent_range_cache i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Applies one operation to the model table and returns the word the block
  // should produce for it. Lookups take the lowest-indexed containing entry;
  // the range end is compared at 33 bits so that an extent never wraps past
  // the top logical block, while the physical block wraps at 2^48.
  function automatic extent_result_t apply_extent_op(input logic [OP_W-1:0] op,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [PHYS_W-1:0] pstart,
                                                     input logic [LEN_W-1:0] len);
    extent_result_t res;
    logic [KEY_W-1:0] offset;
    bit found;
    int i;
    res = NO_HIT;
    found = 1'b0;
    case (op)
      OP_LOOKUP: begin
        n_lookups++;
        for (i = 0; i < ENTRIES; i++) begin
          if (!found && map_valid[i] && key >= map_lstart[i] &&
              33'(key) < 33'(map_lstart[i]) + 33'(map_len[i])) begin
            offset   = key - map_lstart[i];
            res.hit  = 1'b1;
            res.phys = map_pstart[i] + PHYS_W'(offset);
            res.run  = map_len[i] - offset[LEN_W-1:0];
            found    = 1'b1;
          end
        end
        if (found) n_hits++;
      end
      OP_INSERT: begin
        n_inserts++;
        for (i = 0; i < ENTRIES; i++) begin
          if (!found && map_valid[i] && map_lstart[i] == key) begin
            map_pstart[i] = pstart;
            map_len[i]    = len;
            found         = 1'b1;
          end
        end
        if (found) begin
          n_updates++;
        end else begin
          map_lstart[victim_ptr] = key;
          map_pstart[victim_ptr] = pstart;
          map_len[victim_ptr]    = len;
          map_valid[victim_ptr]  = 1'b1;
          victim_ptr = (victim_ptr == ENTRIES - 1) ? 0 : victim_ptr + 1;
        end
      end
      OP_INVAL: begin
        n_wipes++;
        map_valid = '0;
      end
      default: begin
        // The spare code leaves the table alone and answers with zeros.
      end
    endcase
    return res;
  endfunction

  // Presents one word and holds it until the block takes it. On return the
  // word has been accepted at the current edge; in_tvalid is left high unless
  // the sender chose to idle, in which case time has already moved on.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [PHYS_W-1:0] pstart, input logic [LEN_W-1:0] len,
                           input logic typed, input extent_result_t typed_res);
    extent_result_t predicted;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, len, pstart, key};
    do @(posedge clk); while (!in_tready);
    predicted = apply_extent_op(op, key, pstart, len);
    pending_results.push_back(typed ? typed_res : predicted);
    words_sent++;
    if ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Stops sending and lets the block drain every outstanding word. Time always
  // advances, so the next send_word never assigns in_tvalid twice in one step.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Output side: scores each accepted word against the oldest expectation and
  // draws the next out_tready.
  always @(posedge clk) begin : result_check
    extent_result_t want;
    extent_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[PHYS_W-1:0], out_tdata[PHYS_W+LEN_W-1:PHYS_W]};
      words_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected output word hit=%0b phys=%h run=%0d",
                   $time, got.hit, got.phys, got.run);
      end else begin
        want = pending_results.pop_front();
        if (got.hit !== want.hit || got.phys !== want.phys || got.run !== want.run) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: word %0d expected hit=%0b phys=%h run=%0d, got hit=%0b phys=%h run=%0d",
                     $time, words_checked, want.hit, want.phys, want.run,
                     got.hit, got.phys, got.run);
        end
      end
    end
    out_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d words outstanding.",
               cycle_count, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key;
    logic [PHYS_W-1:0] pstart;
    logic [LEN_W-1:0]  len;
    extent_span_t      span;
    int                pick;
    int                offset;
    int                phase;

    map_valid  = '0;
    victim_ptr = 0;

    // Hand-computed rows follow the table contents built up by the inserts
    // above them: entry 0 takes logical 100, entry 1 the extent at the top of
    // the logical space, entry 2 a zero-length extent, and so on.
    directed_rows = '{
      // Empty table after reset: both ends of the key space miss.
      '{OP_LOOKUP, 32'd0,          48'd0,            15'd0,     1'b1, NO_HIT},
      '{OP_LOOKUP, 32'hFFFF_FFFF,  48'd0,            15'd0,     1'b1, NO_HIT},
      // Spare code with every bit set must leave no trace.
      '{OP_UNUSED, 32'hFFFF_FFFF,  48'hFFFF_FFFF_FFFF, 15'h7FFF, 1'b1, NO_HIT},
      '{OP_INSERT, 32'd100,        48'd1000,         15'd10,    1'b1, NO_HIT},
      '{OP_LOOKUP, 32'd100,        48'd0,            15'd0,     1'b1,
        '{1'b1, 48'd1000, 15'd10}},
      '{OP_LOOKUP, 32'd109,        48'd0,            15'd0,     1'b1,
        '{1'b1, 48'd1009, 15'd1}},
      // One past the end and one before the start both miss.
      '{OP_LOOKUP, 32'd110,        48'd0,            15'd0,     1'b1, NO_HIT},
      '{OP_LOOKUP, 32'd99,         48'd0,            15'd0,     1'b1, NO_HIT},
      // Longest extent at the top of the logical space, physical start at
      // its maximum so that the mapped block wraps round.
      '{OP_INSERT, 32'hFFFF_FFF0,  48'hFFFF_FFFF_FFFF, 15'h7FFF, 1'b1, NO_HIT},
      '{OP_LOOKUP, 32'hFFFF_FFFF,  48'd0,            15'd0,     1'b1,
        '{1'b1, 48'h0000_0000_000E, 15'd32752}},
      // The extent must not wrap round to logical block zero.
      '{OP_LOOKUP, 32'd0,          48'd0,            15'd0,     1'b1, NO_HIT},
      // A zero-length extent is stored but never contains anything.
      '{OP_INSERT, 32'd0,          48'd0,            15'd0,     1'b1, NO_HIT},
      '{OP_LOOKUP, 32'd0,          48'd0,            15'd0,     1'b1, NO_HIT},
      // Same logical start again: entry 0 is rewritten in place.
      '{OP_INSERT, 32'd100,        48'd5000,         15'd20,    1'b1, NO_HIT},
      '{OP_LOOKUP, 32'd115,        48'd0,            15'd0,     1'b1,
        '{1'b1, 48'd5015, 15'd5}},
      // Overlapping extent in a higher entry: the lower index must win.
      '{OP_INSERT, 32'd105,        48'd7000,         15'd3,     1'b1, NO_HIT},
      '{OP_LOOKUP, 32'd106,        48'd0,            15'd0,     1'b0, NO_HIT},
      '{OP_INSERT, 32'd50,         48'h8000_0000_0000, 15'd100, 1'b1, NO_HIT},
      '{OP_LOOKUP, 32'd60,         48'd0,            15'd0,     1'b0, NO_HIT},
      '{OP_UNUSED, 32'd100,        48'd0,            15'd0,     1'b1, NO_HIT},
      '{OP_LOOKUP, 32'd100,        48'd0,            15'd0,     1'b1,
        '{1'b1, 48'd5000, 15'd20}},
      // Invalidate empties the table.
      '{OP_INVAL,  32'd100,        48'd0,            15'd0,     1'b1, NO_HIT},
      '{OP_LOOKUP, 32'd100,        48'd0,            15'd0,     1'b0, NO_HIT}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle_pct = 37;
    rcv_idle_pct = 64;
    foreach (directed_rows[r])
      send_word(directed_rows[r].op, directed_rows[r].key, directed_rows[r].pstart,
                directed_rows[r].len, directed_rows[r].typed, directed_rows[r].res);

    // Three random phases: receiver slow, then sender slow, then full rate.
    // Each phase begins with the sender waiting for the block to drain.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin snd_idle_pct = 37; rcv_idle_pct = 64; end
        1:       begin snd_idle_pct = 64; rcv_idle_pct = 37; end
        default: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
      endcase
      drain_results();
      repeat (WORDS_PHASE) begin
        pick   = $urandom_range(99);
        key    = $urandom;
        pstart = {16'($urandom), 32'($urandom)};
        len    = 15'($urandom_range(0, 32767));
        if (pick < 2) begin
          op = OP_UNUSED;
        end else if (pick < 4) begin
          op = OP_INVAL;
          span_pool.delete();
        end else if (pick < 40) begin
          op = OP_INSERT;
          pick = $urandom_range(99);
          if (pick < 25 && span_pool.size() != 0)
            key = span_pool[$urandom_range(0, span_pool.size() - 1)].key;
          else if (pick < 35)
            key = 32'hFFFF_FFFF - 32'($urandom_range(0, 40000));
          else if (pick < 75)
            key = 32'($urandom_range(0, 4095));
          pick = $urandom_range(99);
          if (pick < 10)      len = '0;
          else if (pick < 20) len = 15'h7FFF;
          else if (pick < 60) len = 15'($urandom_range(1, 64));
          if ($urandom_range(9) == 0)
            pstart = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 100));
          span.key = key;
          span.len = len;
          span_pool.push_back(span);
          if (span_pool.size() > POOL_DEPTH) void'(span_pool.pop_front());
        end else begin
          op = OP_LOOKUP;
          if ($urandom_range(99) < 70 && span_pool.size() != 0) begin
            span = span_pool[$urandom_range(0, span_pool.size() - 1)];
            case ($urandom_range(3))
              0:       offset = 0;
              1:       offset = int'(span.len) - 1;
              2:       offset = int'(span.len);
              default: offset = $urandom_range(0, span.len);
            endcase
            key = span.key + 32'(offset);
          end else if ($urandom_range(1) == 0) begin
            key = 32'($urandom_range(0, 8191));
          end
        end
        send_word(op, key, pstart, len, 1'b0, NO_HIT);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words: %0d lookups (%0d hits), %0d inserts (%0d in place), %0d wipes.",
             words_sent, n_lookups, n_hits, n_inserts, n_updates, n_wipes);
    $display("Checked %0d output words under three handshake regimes, %0d mismatches.",
             words_checked, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/erc_pkg.sv
rtl/core/erc_ctrl.sv
rtl/core/erc_datapath.sv
rtl/core/extent_range_cache.sv
bench/testbench.sv
